// ----- rtl/crc8fr_pkg.sv -----
// Shared types, constants and the CRC-8 lookup for the framed packet receiver.
package crc8fr_pkg;

  localparam int unsigned RING_DEPTH_DEF    = 256;
  localparam int unsigned PAYLOAD_BYTES_DEF = 30;

  localparam int unsigned POS_W   = 6;
  localparam int unsigned AVAIL_W = 8;

  localparam logic [7:0] STATUS_QUERY    = 8'hA0;
  localparam logic [7:0] FRAME_MARK      = 8'hA6;
  localparam logic [7:0] REPLY_READY     = 8'd206;
  localparam logic [7:0] REPLY_BUSY      = 8'd238;
  localparam logic [7:0] REPLY_CRC_ERROR = 8'd207;
  localparam logic [7:0] EMPTY_MARK      = 8'hFF;
  localparam logic [7:0] CRC_POLY_REFL   = 8'h8C;

  typedef enum logic [1:0] {
    REQ_LINE = 2'd0,
    REQ_POP  = 2'd1,
    REQ_PEEK = 2'd2
  } req_type_e;

  // Events from the frame parser to the ring control.
  typedef struct packed {
    logic       payload;      // payload byte at the tentative head
    logic       commit;       // CRC good: committed head takes tentative head
    logic       rollback;     // CRC bad or overrun: tentative head falls back
    logic       reply_valid;
    logic [7:0] reply_byte;
  } frame_evt_t;

  // Dallas/Maxim CRC-8 table entry (reflected 0x31, init 0).
  function automatic logic [7:0] crc8_lut(input logic [7:0] idx);
    logic [7:0] v;
    v = idx;
    for (int b = 0; b < 8; b++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY_REFL) : (v >> 1);
    end
    return v;
  endfunction

endpackage

// ----- rtl/crc8_framed_packet_receiver.sv -----
// Top level: framed CRC-8 packet receiver with a payload ring and host reads.
//
// Input stream (s_axis): one beat per request. tuser carries the request
// kind (0 line byte, 1 host pop, 2 host peek, 3 ignored); tdata carries the
// line byte. Output stream (m_axis): exactly one beat per input beat, in order.
// tdata holds the status reply byte, the read byte (0xFF when nothing was
// read) and the committed byte count; tuser holds the two valid flags.
//
// Throughput is one beat per cycle while m_axis keeps up. The ring memory is
// read in the accept cycle and its registered read port is the output data.
// Heads, tail and frame state are flops updated in the accept cycle, so the
// next beat sees them at once. Writes only land past the committed head and
// reads only below it, so a read never meets a byte written the cycle before.
//
// Reset clears frame state, CRC, error flag and all ring pointers (ring
// empty); the ring contents are left as they are. No clearing pass.
// When the m_axis side stalls, the result beat is held and s_axis_tready_o
// drops; the block then accepts one new beat per beat taken downstream.
module crc8_framed_packet_receiver #(
  parameter int unsigned RING_DEPTH    = crc8fr_pkg::RING_DEPTH_DEF,
  parameter int unsigned PAYLOAD_BYTES = crc8fr_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [7:0] reply_byte, [15:8] read_data,
                                        // [23:16] available
  output logic [1:0]  m_axis_tuser_o    // [0] reply_valid, [1] read_valid
);

  localparam int unsigned PTR_W = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

  // Ring pointers
  logic [PTR_W-1:0] committed_q, committed_d;
  logic [PTR_W-1:0] tentative_q, tentative_d;
  logic [PTR_W-1:0] tail_q, tail_d;

  // Output beat register
  logic             out_valid_q;
  logic             reply_valid_q;
  logic [7:0]       reply_byte_q;
  logic             read_valid_q;
  logic [7:0]       avail_q;

  // Ring memory with a registered read port
  logic [7:0]       ring_mem [RING_DEPTH];
  logic [7:0]       rd_data_q;

  logic             accept;
  logic             byte_en;
  logic             host_rd;
  logic             rd_en;
  logic             wr_en;
  logic [PTR_W-1:0] tentative_nx;
  logic             ring_full;
  logic             busy;
  logic [PTR_W-1:0] cnt_now;
  logic [PTR_W-1:0] cnt_next;

  crc8fr_pkg::frame_evt_t evt;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ring_cnt(input logic [PTR_W-1:0] head,
                                                input logic [PTR_W-1:0] tail);
    logic [CNT_W-1:0] wrap;
    wrap = {1'b0, head} + CNT_W'(RING_DEPTH) - {1'b0, tail};
    return (head >= tail) ? head - tail : wrap[PTR_W-1:0];
  endfunction

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign byte_en         = accept && (s_axis_tuser_i == crc8fr_pkg::REQ_LINE);
  assign host_rd         = accept && (s_axis_tuser_i == crc8fr_pkg::REQ_POP ||
                                      s_axis_tuser_i == crc8fr_pkg::REQ_PEEK);
  assign rd_en           = host_rd && (committed_q != tail_q);

  assign tentative_nx = ring_next(tentative_q);
  assign ring_full    = (tentative_nx == tail_q);
  assign cnt_now      = ring_cnt(committed_q, tail_q);
  // free space below one payload
  assign busy         = (PTR_LAST - cnt_now) < PTR_W'(PAYLOAD_BYTES);
  assign wr_en        = evt.payload && !ring_full;

  crc8fr_frame #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_en_i   (byte_en),
    .byte_i      (s_axis_tdata_i),
    .ring_full_i (ring_full),
    .busy_i      (busy),
    .evt_o       (evt)
  );

  // Pointer updates
  always_comb begin
    committed_d = committed_q;
    tentative_d = tentative_q;
    tail_d      = tail_q;
    if (wr_en) begin
      tentative_d = tentative_nx;
    end
    if (evt.rollback) begin
      tentative_d = committed_q;
    end
    if (evt.commit) begin
      committed_d = tentative_q;
    end
    if (rd_en && s_axis_tuser_i == crc8fr_pkg::REQ_POP) begin
      tail_d = ring_next(tail_q);
    end
  end

  assign cnt_next = ring_cnt(committed_d, tail_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      committed_q <= '0;
      tentative_q <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      committed_q <= committed_d;
      tentative_q <= tentative_d;
      tail_q      <= tail_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload, loaded with each accepted beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      reply_valid_q <= evt.reply_valid;
      reply_byte_q  <= evt.reply_byte;
      read_valid_q  <= rd_en;
      avail_q       <= crc8fr_pkg::AVAIL_W'(cnt_next);
    end
  end

  // Ring memory: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[tentative_q] <= s_axis_tdata_i;
    end
    if (rd_en) begin
      rd_data_q <= ring_mem[tail_q];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = {read_valid_q, reply_valid_q};
  assign m_axis_tdata_o  = {avail_q,
                            read_valid_q ? rd_data_q : crc8fr_pkg::EMPTY_MARK,
                            reply_byte_q};

  // every accepted beat shows up as a result beat in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> m_axis_tvalid_o)
    else $error("accepted beat without result");
  // a line byte never produces a read and a host access never a reply
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tuser_o[0] && m_axis_tuser_o[1]))
    else $error("reply and read in one beat");
  // a payload write never moves the tentative head onto the read tail
  assert property (@(posedge clk_i) disable iff (!rst_ni) wr_en |-> (tentative_nx != tail_q))
    else $error("ring write would reach read tail");
  // the committed count never exceeds the ring capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && evt.commit) |=> (ring_cnt(committed_q, tail_q) <= PTR_LAST))
    else $error("committed count beyond capacity");

endmodule

// ----- rtl/crc8fr_frame.sv -----
// Line frame parser: frame position, running CRC, overrun and error flags.
module crc8fr_frame #(
  parameter int unsigned PAYLOAD_BYTES = crc8fr_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     byte_en_i,
  input  logic [7:0]               byte_i,
  input  logic                     ring_full_i,
  input  logic                     busy_i,
  output crc8fr_pkg::frame_evt_t   evt_o
);

  localparam logic [crc8fr_pkg::POS_W-1:0] POS_HDR  = crc8fr_pkg::POS_W'(1);
  localparam logic [crc8fr_pkg::POS_W-1:0] POS_PL0  = crc8fr_pkg::POS_W'(2);
  localparam logic [crc8fr_pkg::POS_W-1:0] POS_PLN  = crc8fr_pkg::POS_W'(PAYLOAD_BYTES + 1);
  localparam logic [crc8fr_pkg::POS_W-1:0] POS_END  = crc8fr_pkg::POS_W'(PAYLOAD_BYTES + 2);
  localparam logic [crc8fr_pkg::POS_W-1:0] POS_CRC  = crc8fr_pkg::POS_W'(PAYLOAD_BYTES + 3);

  logic [crc8fr_pkg::POS_W-1:0] pos_q, pos_d;
  logic [7:0]                   crc_q, crc_d;
  logic                         ovr_q, ovr_d;
  logic                         failed_q, failed_d;

  always_comb begin
    pos_d    = pos_q;
    crc_d    = crc_q;
    ovr_d    = ovr_q;
    failed_d = failed_q;
    evt_o    = '0;
    if (byte_en_i) begin
      if (pos_q >= POS_PL0 && pos_q <= POS_PLN) begin
        evt_o.payload = 1'b1;
        crc_d = crc8fr_pkg::crc8_lut(crc_q ^ byte_i);
        if (ring_full_i) begin
          ovr_d = 1'b1;
        end
        pos_d = pos_q + 1'b1;
      end else if (pos_q == '0 && byte_i == crc8fr_pkg::STATUS_QUERY) begin
        evt_o.reply_valid = 1'b1;
        if (failed_q) begin
          evt_o.reply_byte = crc8fr_pkg::REPLY_CRC_ERROR;
        end else if (busy_i) begin
          evt_o.reply_byte = crc8fr_pkg::REPLY_BUSY;
        end else begin
          evt_o.reply_byte = crc8fr_pkg::REPLY_READY;
        end
      end else if (pos_q == POS_END && byte_i == crc8fr_pkg::FRAME_MARK) begin
        pos_d = pos_q + 1'b1;
      end else if (pos_q == '0 && byte_i == crc8fr_pkg::FRAME_MARK) begin
        crc_d = '0;
        ovr_d = 1'b0;
        pos_d = POS_HDR;
      end else if (pos_q == POS_HDR && byte_i == 8'h00) begin
        pos_d = POS_PL0;
      end else if (pos_q == POS_CRC) begin
        if (crc_q != byte_i || ovr_q) begin
          failed_d       = 1'b1;
          evt_o.rollback = 1'b1;
        end else begin
          failed_d     = 1'b0;
          evt_o.commit = 1'b1;
        end
        crc_d = '0;
        ovr_d = 1'b0;
        pos_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      crc_q    <= '0;
      ovr_q    <= 1'b0;
      failed_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      crc_q    <= crc_d;
      ovr_q    <= ovr_d;
      failed_q <= failed_d;
    end
  end

  // frame position never runs past the CRC byte
  assert property (@(posedge clk_i) disable iff (!rst_ni) pos_q <= POS_CRC)
    else $error("frame position out of range");
  // a CRC byte ends in exactly one of commit or rollback
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_en_i && pos_q == POS_CRC) |-> (evt_o.commit ^ evt_o.rollback))
    else $error("CRC byte without single outcome");
  // the state after a CRC byte is idle with a clean CRC
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_en_i && pos_q == POS_CRC) |=> (pos_q == '0 && crc_q == '0 && !ovr_q))
    else $error("frame not closed after CRC byte");

endmodule
